// ----- hdl/isu_pkg.sv -----
`default_nettype none

package isu_pkg;

  // default table size
  localparam int TABLE_DEPTH_DEFAULT = 256;

  // fixed field widths
  localparam int KeyW   = 32;
  localparam int IdxW   = 8;
  // search bounds run from -1 up to 256
  localparam int SIdxW  = 10;
  localparam int UpcW   = 4;
  // quotient bits per probe: the probe offset never exceeds high - low
  localparam int DivSteps = 8;

  // input request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef logic [UpcW-1:0] upc_t;
  typedef logic signed [SIdxW-1:0] sidx_t;

  // microprogram addresses
  localparam upc_t UPC_IDLE   = 4'd0;
  localparam upc_t UPC_RD_LO  = 4'd1;
  localparam upc_t UPC_RD_HI  = 4'd2;
  localparam upc_t UPC_CHECK  = 4'd3;
  localparam upc_t UPC_MUL    = 4'd4;
  localparam upc_t UPC_DIV    = 4'd5;
  localparam upc_t UPC_PROBE  = 4'd6;
  localparam upc_t UPC_CMP    = 4'd7;
  localparam upc_t UPC_RESULT = 4'd8;

  // datapath operation of one control word
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_RD_LO,
    OP_RD_HI,
    OP_CHECK,
    OP_MUL,
    OP_DIV,
    OP_PROBE,
    OP_CMP,
    OP_RESULT
  } uop_e;

  // branch condition of one control word
  typedef enum logic [2:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_EMPTY,
    BR_OUTSIDE,
    BR_FLAT,
    BR_DIV_MORE,
    BR_NO_HIT
  } br_e;

  typedef struct packed {
    uop_e op;
    br_e  br;
    upc_t target;
  } uword_t;

  // control store
  function automatic uword_t ucode_rom(upc_t upc);
    uword_t w;
    unique case (upc)
      UPC_IDLE:   w = '{op: OP_IDLE,   br: BR_NEVER,    target: UPC_IDLE};
      UPC_RD_LO:  w = '{op: OP_RD_LO,  br: BR_EMPTY,    target: UPC_RESULT};
      UPC_RD_HI:  w = '{op: OP_RD_HI,  br: BR_NEVER,    target: UPC_IDLE};
      UPC_CHECK:  w = '{op: OP_CHECK,  br: BR_OUTSIDE,  target: UPC_RESULT};
      UPC_MUL:    w = '{op: OP_MUL,    br: BR_FLAT,     target: UPC_PROBE};
      UPC_DIV:    w = '{op: OP_DIV,    br: BR_DIV_MORE, target: UPC_DIV};
      UPC_PROBE:  w = '{op: OP_PROBE,  br: BR_NEVER,    target: UPC_IDLE};
      UPC_CMP:    w = '{op: OP_CMP,    br: BR_NO_HIT,   target: UPC_RD_LO};
      UPC_RESULT: w = '{op: OP_RESULT, br: BR_ALWAYS,   target: UPC_IDLE};
      default:    w = '{op: OP_RD_HI,  br: BR_ALWAYS,   target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/interpolation_search_table_unit.sv -----
// interpolation search over a table of signed 32-bit entries
//
// input channel (in_valid_i / in_ready_o): req_type_i = 0 writes item_value_i
// into entry entry_index_i (indexes past the table are dropped), no result.
// req_type_i = 1 searches entries 0..last_index for the key item_value_i.
// output channel (out_valid_o / out_ready_i): one transfer per search with
// found_o and found_index_o (zero when not found).
// config channel (cfg_valid_i / cfg_ready_o): cfg_data_i sets last_index,
// always ready; write it only while the block is idle.
//
// steps: a write is stored when it is accepted. a search takes an accept
// step, a result step and per probe up to three table reads, a check, a
// multiply, 8 divider steps, a compare; a flat span skips the divider.
// the probe loop is set by the bit-serial divider and the single read port
// of the table. one item is in work at a time.
// the result sits in an output register: writes are still taken while it
// waits, a following search stalls in its result step until the receiver
// takes the pending transfer.
// reset clears the control and last_index; table contents stay undefined
// until written.
`default_nettype none

module interpolation_search_table_unit
  import isu_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config transfer
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [IdxW-1:0]        cfg_data_i,
  // input transfer
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   req_type_i,
  input  wire logic [IdxW-1:0]        entry_index_i,
  input  wire logic signed [KeyW-1:0] item_value_i,
  // output transfer
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        found_o,
  output logic [IdxW-1:0]             found_index_o
);

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // microsequencer
  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   go;
  logic   br_take;

  // config
  logic [IdxW-1:0] last_index_q;

  // datapath
  logic signed [KeyW-1:0] key_q;
  logic signed [KeyW-1:0] tl_q;
  logic [KeyW-1:0]        dk_q;     // key - t[low]
  logic [KeyW-1:0]        den_q;    // t[high] - t[low]
  logic [KeyW-1:0]        rem_q;    // divider remainder
  logic [IdxW-1:0]        divq_q;   // dividend low bits, then quotient
  logic [2:0]             div_cnt_q;
  sidx_t                  lo_q;
  sidx_t                  hi_q;
  logic [IdxW-1:0]        pos_q;
  logic                   hit_q;

  // table
  logic [KeyW-1:0]        mem [TABLE_DEPTH];
  logic signed [KeyW-1:0] rd_data_q;
  logic [AddrW-1:0]       rd_addr;
  logic                   wr_en;

  // output register
  logic            out_valid_q;
  logic            found_q;
  logic [IdxW-1:0] found_index_q;

  // combinational helpers
  logic            in_acc;
  logic            search_acc;
  logic            out_free;
  logic            outside;
  logic            cmp_hit;
  logic [IdxW-1:0] span;
  logic [IdxW+KeyW-1:0] prod;
  logic [KeyW:0]   trial;
  logic            trial_ge;
  logic [IdxW-1:0] pos_new;

  assign uw          = ucode_rom(upc_q);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (upc_q == UPC_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign search_acc  = in_acc && (req_type_i == REQ_SEARCH);
  assign wr_en       = in_acc && (req_type_i == REQ_WRITE) &&
                       (32'(entry_index_i) < TABLE_DEPTH);
  assign out_free    = !out_valid_q || out_ready_i;

  // key must lie inside t[low]..t[high]; rd_data_q holds t[high] here
  assign outside  = (key_q < tl_q) || (key_q > rd_data_q);
  assign cmp_hit  = (rd_data_q == key_q);
  assign span     = IdxW'(hi_q - lo_q);
  assign prod     = span * dk_q;
  assign trial    = {rem_q, divq_q[IdxW-1]};
  assign trial_ge = (trial >= {1'b0, den_q});
  assign pos_new  = lo_q[IdxW-1:0] + divq_q;

  // step completion and branch decode
  always_comb begin
    unique case (uw.op)
      OP_IDLE:   go = search_acc;
      OP_RESULT: go = out_free;
      default:   go = 1'b1;
    endcase

    unique case (uw.br)
      BR_NEVER:    br_take = 1'b0;
      BR_ALWAYS:   br_take = 1'b1;
      BR_EMPTY:    br_take = (lo_q > hi_q);
      BR_OUTSIDE:  br_take = outside;
      BR_FLAT:     br_take = (den_q == '0);
      BR_DIV_MORE: br_take = (div_cnt_q != 3'(DivSteps - 1));
      BR_NO_HIT:   br_take = !cmp_hit;
      default:     br_take = 1'b0;
    endcase

    if (!go) begin
      upc_d = upc_q;
    end else if (br_take) begin
      upc_d = uw.target;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  // table read address
  always_comb begin
    unique case (uw.op)
      OP_RD_LO: rd_addr = AddrW'(lo_q[IdxW-1:0]);
      OP_RD_HI: rd_addr = AddrW'(hi_q[IdxW-1:0]);
      default:  rd_addr = AddrW'(pos_new);
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q        <= UPC_IDLE;
      last_index_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_valid_i && cfg_ready_o) begin
        last_index_q <= cfg_data_i;
      end
      if (uw.op == OP_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AddrW'(entry_index_i)] <= item_value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      OP_IDLE: begin
        if (search_acc) begin
          key_q <= item_value_i;
          lo_q  <= '0;
          hit_q <= 1'b0;
          // clamp the search bound to the table
          if (32'(last_index_q) > TABLE_DEPTH - 1) begin
            hi_q <= $signed(SIdxW'(TABLE_DEPTH - 1));
          end else begin
            hi_q <= $signed({2'b00, last_index_q});
          end
        end
      end
      OP_RD_HI: begin
        tl_q <= rd_data_q;
      end
      OP_CHECK: begin
        dk_q  <= KeyW'(key_q - tl_q);
        den_q <= KeyW'(rd_data_q - tl_q);
      end
      OP_MUL: begin
        rem_q     <= prod[IdxW+KeyW-1:IdxW];
        divq_q    <= (den_q == '0) ? '0 : prod[IdxW-1:0];
        div_cnt_q <= '0;
      end
      OP_DIV: begin
        // restoring step, one quotient bit per cycle
        rem_q     <= trial_ge ? KeyW'(trial - {1'b0, den_q}) : trial[KeyW-1:0];
        divq_q    <= {divq_q[IdxW-2:0], trial_ge};
        div_cnt_q <= div_cnt_q + 3'd1;
      end
      OP_PROBE: begin
        pos_q <= pos_new;
      end
      OP_CMP: begin
        if (cmp_hit) begin
          hit_q <= 1'b1;
        end else if (key_q < rd_data_q) begin
          hi_q <= $signed({2'b00, pos_q}) - sidx_t'(1);
        end else begin
          lo_q <= $signed({2'b00, pos_q}) + sidx_t'(1);
        end
      end
      OP_RESULT: begin
        if (out_free) begin
          found_q       <= hit_q;
          found_index_q <= hit_q ? pos_q : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign found_index_o = found_index_q;

  // a miss always reports index zero
  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> found_index_o == '0)
    else $error("miss result with nonzero index");

  // a new result only comes out of the result step
  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(upc_q) == UPC_RESULT)
    else $error("result raised outside the result step");

  // an accepted search keeps the input side closed for the next cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_SEARCH) |=> !in_ready_o)
    else $error("input open right after a search transfer");

endmodule

`default_nettype wire

// ----- tb/sv/interpolation_search_table_unit_tb.sv -----
`timescale 1ns / 1ps

module interpolation_search_table_unit_tb;
  import isu_pkg::*;

  // signed 32-bit key range, held in 64-bit math
  localparam longint KEY_MIN = -64'sd2147483648;
  localparam longint KEY_MAX = 64'sd2147483647;

  // cycles with no transfer on any channel before the run is declared hung:
  // a worst-case search probes every entry and may sit behind the long
  // receiver hold-off, so this leaves a wide margin
  localparam int QUIET_LIMIT = 20000;
  // the receiver hold-off that backs up the block and stalls its input
  localparam int HOLD_CYCLES = 300;
  // a write finishes on its accept; give the block a little slack before
  // touching last_index
  localparam int WRITE_SETTLE = 16;
  // stimulus size: the directed part plus about 500 random items
  localparam int ITEM_TARGET = 525;

  // value distributions used to fill the table for one phase
  typedef enum int {
    SHAPE_DENSE,
    SHAPE_WIDE,
    SHAPE_SKEW,
    SHAPE_FLAT,
    SHAPE_JUMBLE
  } shape_e;

  typedef struct {
    logic             kind;
    logic [IdxW-1:0]  slot;
    logic [KeyW-1:0]  value;
  } req_item_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] index;
  } search_result_t;

  // dut ports, inputs all known from time zero
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [IdxW-1:0]        cfg_data_i    = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_ready_o;
  logic                   req_type_i    = REQ_WRITE;
  logic [IdxW-1:0]        entry_index_i = '0;
  logic signed [KeyW-1:0] item_value_i  = '0;
  logic                   out_valid_o;
  logic                   out_ready_i   = 1'b0;
  logic                   found_o;
  logic [IdxW-1:0]        found_index_o;

  // requests waiting to go out on the input channel
  req_item_t      req_queue[$];
  // search answers still owed by the block, oldest first
  search_result_t lookups_due[$];

  // predictor state: mirror of the table and of last_index, updated on transfers
  logic signed [KeyW-1:0] entry_copy [TABLE_DEPTH_DEFAULT] = '{default: '0};
  logic [IdxW-1:0]        bound_copy = '0;

  // stimulus-side picture of the table, used only to choose useful keys
  longint plan_vals [TABLE_DEPTH_DEFAULT];

  int mismatches    = 0;
  int queued_items  = 0;
  int send_gap      = 0;
  int send_calm     = 0;
  int recv_wait     = 0;
  int recv_calm     = 0;
  int results_taken = 0;
  int quiet_cycles  = 0;
  int next_wait;
  bit held_off      = 1'b0;
  req_item_t      next_req;
  search_result_t want;

  interpolation_search_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .found_index_o (found_index_o)
  );

  always #6 clk_i = ~clk_i;

  // per-item random wait, with occasional calm stretches of no waiting
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // interpolation search over the mirrored table, exact 64-bit arithmetic;
  // a flat span probes its low end
  function automatic search_result_t interp_lookup(input logic signed [KeyW-1:0] key);
    search_result_t res;
    longint lo, hi, k, tl, th, tp, pos;
    bit done;
    res  = '{found: 1'b0, index: '0};
    k    = key;
    lo   = 0;
    hi   = bound_copy;
    done = 1'b0;
    while (!done && lo <= hi) begin
      tl = entry_copy[lo];
      th = entry_copy[hi];
      if (k < tl || k > th) begin
        // key outside the span: not found
        done = 1'b1;
      end else begin
        pos = (th == tl) ? lo : lo + (hi - lo) * (k - tl) / (th - tl);
        tp  = entry_copy[pos];
        if (k == tp) begin
          res.found = 1'b1;
          res.index = pos[IdxW-1:0];
          done      = 1'b1;
        end else if (k < tp) begin
          hi = pos - 1;
        end else begin
          lo = pos + 1;
        end
      end
    end
    return res;
  endfunction

  // pick a search key near the planned table contents
  function automatic longint pick_key(input int bound);
    int r;
    r = $urandom_range(0, bound);
    case ($urandom_range(0, 9))
      6:       return plan_vals[r] + 1;
      7:       return plan_vals[r] - 1;
      8:       return longint'($signed($urandom));
      9:       return $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
      default: return plan_vals[r];
    endcase
  endfunction

  task automatic push_write(input int slot, input longint value);
    req_item_t it;
    it.kind  = REQ_WRITE;
    it.slot  = slot[IdxW-1:0];
    it.value = value[KeyW-1:0];
    req_queue.push_back(it);
    queued_items++;
  endtask

  task automatic push_search(input longint key);
    req_item_t it;
    it.kind  = REQ_SEARCH;
    // entry_index is a don't-care on a search, so keep it moving
    it.slot  = IdxW'($urandom_range(0, 255));
    it.value = key[KeyW-1:0];
    req_queue.push_back(it);
    queued_items++;
  endtask

  // wait until every request is sent and every answer is back, then let a
  // trailing write finish; sampled on the falling edge to stay clear of the
  // driver updating at the rising one
  task automatic settle();
    @(negedge clk_i);
    while (req_queue.size() != 0 || in_valid_i || lookups_due.size() != 0)
      @(negedge clk_i);
    repeat (WRITE_SETTLE) @(posedge clk_i);
  endtask

  // one config transfer setting last_index
  task automatic set_bound(input int bound);
    @(posedge clk_i);
    cfg_data_i  <= bound[IdxW-1:0];
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // fill entries 0..bound with one distribution, then a run of searches mixed
  // with order-keeping overwrites and writes past the searched range
  task automatic run_phase(input int bound, input shape_e shape);
    longint cur, lo_v, hi_v, span;
    int n_search, slot;
    bit downward;
    case (shape)
      SHAPE_WIDE: cur = KEY_MIN + $urandom_range(0, 1000);
      SHAPE_SKEW: cur = longint'($urandom_range(0, 2000)) - 1000;
      default:    cur = longint'($signed($urandom));
    endcase
    span = (longint'(1) << 32) / (bound + 1);
    for (int i = 0; i <= bound; i++) begin
      if (i > 0) begin
        case (shape)
          SHAPE_DENSE: cur += $urandom_range(0, 3);
          SHAPE_WIDE:  cur += longint'($urandom) % span;
          // roughly exponential growth drives many probes per search
          SHAPE_SKEW:  cur += longint'(1) << $urandom_range(0, (i < 31) ? i : 31);
          SHAPE_FLAT:  cur += ($urandom_range(0, 7) == 0);
          default:     cur = longint'($signed($urandom));
        endcase
      end
      if (cur > KEY_MAX) cur = KEY_MAX;
      plan_vals[i] = cur;
    end
    downward = $urandom_range(0, 1);
    for (int i = 0; i <= bound; i++) begin
      slot = downward ? bound - i : i;
      push_write(slot, plan_vals[slot]);
    end
    n_search = (bound == 0) ? 20 : $urandom_range(25, 50);
    for (int s = 0; s < n_search; s++) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          // overwrite between the neighbors so the order mostly holds
          slot = $urandom_range(0, bound);
          lo_v = (slot > 0) ? plan_vals[slot-1] : KEY_MIN;
          hi_v = (slot < bound) ? plan_vals[slot+1] : KEY_MAX;
          cur  = (hi_v < lo_v) ? longint'($signed($urandom))
                               : lo_v + longint'($urandom) % (hi_v - lo_v + 1);
          plan_vals[slot] = cur;
          push_write(slot, cur);
        end
        2: begin
          if (bound < 255) push_write($urandom_range(bound + 1, 255),
                                      longint'($signed($urandom)));
          else push_search(pick_key(bound));
        end
        default: push_search(pick_key(bound));
      endcase
    end
  endtask

  // input driver: presents the next request once the last one transferred,
  // after its drawn gap; valid holds with a stable payload until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      req_type_i    <= REQ_WRITE;
      entry_index_i <= '0;
      item_value_i  <= '0;
      send_gap      <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (req_queue.size() > 0) begin
        next_req       = req_queue.pop_front();
        in_valid_i    <= 1'b1;
        req_type_i    <= next_req.kind;
        entry_index_i <= next_req.slot;
        item_value_i  <= next_req.value;
        send_gap      <= draw_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: random ready gaps per result, plus one long hold-off while
  // plenty of requests are still queued so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      results_taken <= results_taken + 1;
      if (!held_off && results_taken >= 10 && req_queue.size() > 15) begin
        held_off    <= 1'b1;
        recv_wait   <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        next_wait    = draw_gap(recv_calm);
        recv_wait   <= next_wait;
        out_ready_i <= (next_wait == 0);
      end
    end else if (recv_wait > 0) begin
      recv_wait   <= recv_wait - 1;
      out_ready_i <= (recv_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // request monitor: updates the mirrors and queues the answer of each search
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) bound_copy = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        if (req_type_i == REQ_WRITE) entry_copy[entry_index_i] = item_value_i;
        else lookups_due.push_back(interp_lookup(item_value_i));
      end
    end
  end

  // result monitor: each transfer against the oldest outstanding answer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lookups_due.size() == 0) begin
        $error("result with no search outstanding: found %0b found_index %0d",
               found_o, found_index_o);
        mismatches++;
      end else begin
        want = lookups_due.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, found_o);
          mismatches++;
        end
        if (found_index_o !== want.index) begin
          $error("found_index: expected %0d, actual %0d", want.index, found_index_o);
          mismatches++;
        end
      end
    end
  end

  // hang detection: any transfer on any channel resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_no;
    int bound;
    shape_e shape;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // last_index at its reset value: a single-entry table holding the minimum
    push_write(0, KEY_MIN);
    push_write(255, KEY_MAX);
    push_search(KEY_MIN);
    push_search(KEY_MAX);
    settle();

    // four entries with a duplicate and both key extremes: the widest span
    set_bound(3);
    push_write(0, KEY_MIN);
    push_write(1, -5);
    push_write(2, -5);
    push_write(3, KEY_MAX);
    push_search(-5);
    push_search(KEY_MAX);
    push_search(KEY_MIN);
    push_search(0);
    // flat table: probe falls on the low end, anything else is outside
    for (int i = 0; i < 4; i++) push_write(i, 7);
    push_search(7);
    push_search(8);
    // out-of-order table: the search still has to terminate
    push_write(0, 10);
    push_write(1, 50);
    push_write(2, 5);
    push_write(3, 20);
    push_search(5);
    push_search(15);
    push_search(50);
    settle();

    // random phases: full table first, then a single entry, then a mix
    // weighted toward small tables
    phase_no = 0;
    while (queued_items < ITEM_TARGET) begin
      if (phase_no == 0) begin
        bound = 255;
        shape = SHAPE_WIDE;
      end else if (phase_no == 1) begin
        bound = 0;
        shape = SHAPE_DENSE;
      end else begin
        shape = shape_e'($urandom_range(0, 4));
        case ($urandom_range(0, 5))
          0:       bound = 0;
          1:       bound = $urandom_range(128, 255);
          default: bound = $urandom_range(1, 40);
        endcase
        // exponential tables make long probe chains, keep them short
        if (shape == SHAPE_SKEW && bound > 40) bound = $urandom_range(1, 40);
      end
      // keep the last phase close to the item budget
      if (bound > ITEM_TARGET - queued_items) bound = ITEM_TARGET - queued_items;
      set_bound(bound);
      run_phase(bound, shape);
      settle();
      phase_no++;
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- interpolation_search_table_unit.f -----
hdl/isu_pkg.sv
hdl/interpolation_search_table_unit.sv
tb/sv/interpolation_search_table_unit_tb.sv
